### design/stmf_pkg.sv
package stmf_pkg;

   localparam int WINDOW   = 50;
   localparam int SAMPLE_W = 16;
   localparam int TRIM_W   = 6;
   localparam int AGE_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
   localparam int LIM_W    = TRIM_W + 1;
   localparam int DCNT_W   = $clog2(SUM_W + 1);
   localparam int CSR_IDX_W = 1;

   localparam logic [TRIM_W-1:0] DROP_LO_RESET = TRIM_W'(10);
   localparam logic [TRIM_W-1:0] DROP_HI_RESET = TRIM_W'(10);

   localparam logic [CSR_IDX_W-1:0] CSR_DROP_LO = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_HI = 1'b1;

   // one window entry: sample value and how many words ago it arrived
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic [AGE_W-1:0]           age;
   } entry_type;

   // left-to-right chain between cells
   typedef struct packed {
      logic del;  // oldest entry sits at or left of this cell
      logic gp;   // entry landing here after removal is above the new sample
   } link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_HOLD
   } state_type;

endpackage

### design/stmf_req_if.sv
interface stmf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [stmf_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### design/stmf_rsp_if.sv
interface stmf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [stmf_pkg::SAMPLE_W-1:0] trimmed_mean;
   logic                                 trim_error;

   modport source (output valid, output trimmed_mean, output trim_error, input ready);
   modport sink   (input valid, input trimmed_mean, input trim_error, output ready);
endinterface

### design/stmf_cell.sv
module stmf_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic signed [stmf_pkg::SAMPLE_W-1:0] sample,
   input  logic [stmf_pkg::AGE_W-1:0]           index,
   input  logic [stmf_pkg::TRIM_W-1:0]          drop_lo,
   input  logic [stmf_pkg::TRIM_W-1:0]          drop_hi,
   input  stmf_pkg::entry_type                  left_ent,
   input  stmf_pkg::link_type                   left_link,
   input  stmf_pkg::entry_type                  right_ent,
   input  logic                                 right_gt,
   output stmf_pkg::entry_type                  ent,
   output stmf_pkg::link_type                   link,
   output logic                                 gt,
   input  logic signed [stmf_pkg::SUM_W-1:0]    acc_in,
   input  logic                                 tok_in,
   output logic signed [stmf_pkg::SUM_W-1:0]    acc_out,
   output logic                                 tok_out
);

   stmf_pkg::entry_type               ent_ff;
   stmf_pkg::entry_type               ent_in;
   stmf_pkg::entry_type               own_side;
   stmf_pkg::entry_type               left_side;
   logic                              oldest;
   logic                              keep;
   logic signed [stmf_pkg::SUM_W-1:0] acc_ff;
   logic signed [stmf_pkg::SUM_W-1:0] acc_in_sum;
   logic                              tok_ff;

   assign oldest   = (ent_ff.age == stmf_pkg::AGE_W'(stmf_pkg::WINDOW - 1));
   assign gt       = ($signed(ent_ff.value) > sample);
   assign link.del = left_link.del | oldest;
   assign link.gp  = link.del ? right_gt : gt;

   // window after removing the oldest entry, seen at this slot and at the one to the left
   assign own_side  = link.del ? right_ent : ent_ff;
   assign left_side = left_link.del ? ent_ff : left_ent;

   always_comb begin
      priority if (!link.gp) begin
         ent_in.value = own_side.value;
         ent_in.age   = own_side.age + 1'b1;
      end else if (!left_link.gp) begin
         ent_in.value = sample;
         ent_in.age   = '0;
      end else begin
         ent_in.value = left_side.value;
         ent_in.age   = left_side.age + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.value <= '0;
         ent_ff.age   <= index;
      end else if (load) begin
         ent_ff <= ent_in;
      end
   end

   assign ent = ent_ff;

   // running sum moves one cell per cycle; only ranks inside the trims add in
   assign keep = (stmf_pkg::LIM_W'(index) >= stmf_pkg::LIM_W'(drop_lo)) &&
                 (stmf_pkg::LIM_W'(index) + stmf_pkg::LIM_W'(drop_hi) <
                  stmf_pkg::LIM_W'(stmf_pkg::WINDOW));

   assign acc_in_sum = acc_in + (keep ? stmf_pkg::SUM_W'($signed(ent_ff.value)) : '0);

   always_ff @(posedge clock) begin
      acc_ff <= acc_in_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign acc_out = acc_ff;
   assign tok_out = tok_ff;

endmodule

### design/stmf_div.sv
module stmf_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [stmf_pkg::SUM_W-1:0]    dividend,
   input  logic [stmf_pkg::CNT_W-1:0]           divisor,
   output logic                                 done,
   output logic signed [stmf_pkg::SAMPLE_W-1:0] quotient
);

   logic [stmf_pkg::SUM_W-1:0]  mag;
   logic [stmf_pkg::SUM_W-1:0]  dvd_ff;
   logic [stmf_pkg::SUM_W-1:0]  dvd_in;
   logic [stmf_pkg::CNT_W-1:0]  rem_ff;
   logic [stmf_pkg::CNT_W-1:0]  rem_in;
   logic [stmf_pkg::CNT_W-1:0]  den_ff;
   logic [stmf_pkg::CNT_W:0]    shifted;
   logic [stmf_pkg::CNT_W:0]    diff;
   logic                        fits;
   logic                        neg_ff;
   logic [stmf_pkg::DCNT_W-1:0] cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [stmf_pkg::SAMPLE_W-1:0] qmag;

   assign mag = dividend[stmf_pkg::SUM_W-1] ? stmf_pkg::SUM_W'(-dividend)
                                            : stmf_pkg::SUM_W'(dividend);

   // restoring step: one quotient bit per cycle, shifted into the dividend register
   assign shifted = {rem_ff, dvd_ff[stmf_pkg::SUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});
   assign rem_in  = fits ? diff[stmf_pkg::CNT_W-1:0] : shifted[stmf_pkg::CNT_W-1:0];
   assign dvd_in  = {dvd_ff[stmf_pkg::SUM_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= mag;
         rem_ff <= '0;
         den_ff <= divisor;
         neg_ff <= dividend[stmf_pkg::SUM_W-1];
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= stmf_pkg::DCNT_W'(stmf_pkg::SUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == stmf_pkg::DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign qmag     = dvd_ff[stmf_pkg::SAMPLE_W-1:0];
   assign quotient = neg_ff ? $signed(stmf_pkg::SAMPLE_W'(-qmag)) : $signed(qmag);
   assign done     = done_ff;

endmodule

### design/sliding_trimmed_mean_filter_top.sv
// Channel   Dir  Word                            Handshake
// req_chan  in   sample (s16)                    valid/ready
// rsp_chan  out  trimmed_mean (s16), trim_error  valid/ready
// csr_*     in   low / high drop counts (6b)     csr_we, no wait
//
// One sample at a time: the running sum walks the cell row one cell per cycle, then
// the one-bit-per-cycle divider divides the kept sum by the kept count, and the
// quotient passes from the hold state into the output register as the result.
// The sorted row updates at the accept edge. Synchronous reset loads an all-zero
// window and drop counts of 10. A new sample is taken while the last result still
// waits in the output register; a finished mean waits until that register frees.
module sliding_trimmed_mean_filter_top (
   input  logic                               clock,
   input  logic                               reset,
   stmf_req_if.sink                           req_chan,
   stmf_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [stmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [stmf_pkg::TRIM_W-1:0]        csr_wdata
);

   localparam int W = stmf_pkg::WINDOW;

   stmf_pkg::state_type               state_ff;
   stmf_pkg::state_type               state_in;
   logic [stmf_pkg::TRIM_W-1:0]       drop_lo_ff;
   logic [stmf_pkg::TRIM_W-1:0]       drop_hi_ff;
   logic                              accept;
   logic                              start_ff;
   logic                              sum_done;
   logic                              div_start;
   logic                              div_done;
   logic                              out_load;
   logic [stmf_pkg::LIM_W-1:0]        trim_sum;
   logic                              trim_err;
   logic [stmf_pkg::CNT_W-1:0]        kept;
   logic signed [stmf_pkg::SAMPLE_W-1:0] quotient;
   logic                              rsp_valid_ff;
   logic signed [stmf_pkg::SAMPLE_W-1:0] rsp_mean_ff;
   logic                              rsp_err_ff;

   stmf_pkg::entry_type               ents  [W];
   stmf_pkg::link_type                links [W];
   logic                              gts   [W];
   logic signed [stmf_pkg::SUM_W-1:0] accs  [W+1];
   logic                              toks  [W+1];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_lo_ff <= stmf_pkg::DROP_LO_RESET;
         drop_hi_ff <= stmf_pkg::DROP_HI_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            stmf_pkg::CSR_DROP_LO: drop_lo_ff <= csr_wdata;
            stmf_pkg::CSR_DROP_HI: drop_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign trim_sum = stmf_pkg::LIM_W'(drop_lo_ff) + stmf_pkg::LIM_W'(drop_hi_ff);
   assign trim_err = (trim_sum >= stmf_pkg::LIM_W'(W));
   assign kept     = trim_err ? stmf_pkg::CNT_W'(1)
                              : stmf_pkg::CNT_W'(stmf_pkg::LIM_W'(W) - trim_sum);

   // sorted cell row
   assign accs[0] = '0;
   assign toks[0] = start_ff;

   for (genvar i = 0; i < W; i++) begin : g_cell
      stmf_pkg::entry_type left_ent;
      stmf_pkg::link_type  left_link;
      stmf_pkg::entry_type right_ent;
      logic                right_gt;

      if (i == 0) begin : g_first
         assign left_ent  = '0;
         assign left_link = '0;
      end else begin : g_mid_left
         assign left_ent  = ents[i-1];
         assign left_link = links[i-1];
      end

      if (i == W - 1) begin : g_last
         assign right_ent = '0;
         assign right_gt  = 1'b1;
      end else begin : g_mid_right
         assign right_ent = ents[i+1];
         assign right_gt  = gts[i+1];
      end

      stmf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (accept),
         .sample    (req_chan.sample),
         .index     (stmf_pkg::AGE_W'(i)),
         .drop_lo   (drop_lo_ff),
         .drop_hi   (drop_hi_ff),
         .left_ent  (left_ent),
         .left_link (left_link),
         .right_ent (right_ent),
         .right_gt  (right_gt),
         .ent       (ents[i]),
         .link      (links[i]),
         .gt        (gts[i]),
         .acc_in    (accs[i]),
         .tok_in    (toks[i]),
         .acc_out   (accs[i+1]),
         .tok_out   (toks[i+1])
      );
   end

   assign sum_done = toks[W];

   stmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (accs[W]),
      .divisor  (kept),
      .done     (div_done),
      .quotient (quotient)
   );

   // control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stmf_pkg::ST_IDLE: if (req_chan.valid) state_in = stmf_pkg::ST_SUM;
         stmf_pkg::ST_SUM:  if (sum_done) state_in = stmf_pkg::ST_DIV;
         stmf_pkg::ST_DIV:  if (div_done) state_in = stmf_pkg::ST_HOLD;
         stmf_pkg::ST_HOLD: if (!rsp_valid_ff || rsp_chan.ready) state_in = stmf_pkg::ST_IDLE;
         default:           state_in = stmf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == stmf_pkg::ST_IDLE);
      div_start      = (state_ff == stmf_pkg::ST_SUM) && sum_done;
      out_load       = (state_ff == stmf_pkg::ST_HOLD) && (!rsp_valid_ff || rsp_chan.ready);
   end

   assign accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stmf_pkg::ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_mean_ff <= trim_err ? '0 : quotient;
         rsp_err_ff  <= trim_err;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.trimmed_mean = rsp_mean_ff;
   assign rsp_chan.trim_error   = rsp_err_ff;

   a_accept_starts_sum: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == stmf_pkg::ST_SUM))
      else $error("sum did not start after accepted word");

   a_sum_done_in_sum: assert property (@(posedge clock) disable iff (reset)
      sum_done |-> (state_ff == stmf_pkg::ST_SUM))
      else $error("running sum left the row outside the sum phase");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == stmf_pkg::ST_DIV))
      else $error("divider finished outside the divide phase");

   a_err_zero_mean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_mean_ff == '0))
      else $error("trim error with nonzero mean");

endmodule
